// ===== sv/smix_pkg.sv =====
// ----------------------------------------------------------------------------
// smix_pkg: shared types and constants for the stereo pan mixer
// Holds the sample and gain types, the configuration register bundle, the
// stage enable bundle and the register indexes of the configuration port.
// ----------------------------------------------------------------------------
package smix_pkg;

  localparam int MAX_CH    = 4;
  localparam int SAMPLE_W  = 16;
  localparam int FIELD_W   = 16;
  localparam int MG_W      = 32;
  localparam int FACTOR_W  = 16;
  localparam int SCALED_W  = 48;
  localparam int GAIN_W    = 24;
  localparam int TERM_W    = 41;
  localparam int SUM_W     = 43;
  localparam int OUT_SHIFT = 16;
  localparam int REG_IDX_W = 3;
  localparam int CFG_W     = 64;

  localparam logic [REG_IDX_W-1:0] REG_MASTER_GAIN   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CHANNEL_GAINS = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CHANNEL_PANS  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MUTE_MASK     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SOLO_CHANNEL  = 3'd4;

  localparam logic [15:0] MASTER_RESET = 16'd4096;
  localparam logic [63:0] GAINS_RESET  = 64'h4000_4000_4000_4000;
  localparam logic [63:0] PANS_RESET   = 64'h0;
  localparam logic [3:0]  MUTE_RESET   = 4'h0;
  localparam logic [2:0]  SOLO_NONE    = 3'd4;

  // Unity pan factor in Q.14 and the half LSB used when dropping 24 bits.
  localparam logic signed [FIELD_W-1:0] PAN_UNITY  = 16'sd16384;
  localparam logic [SCALED_W-1:0]       ROUND_Q24  = 48'h80_0000;
  localparam logic signed [SUM_W-1:0]   ROUND_Q16  = 43'sd32768;
  localparam logic signed [SAMPLE_W-1:0] OUT_MAX   = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] OUT_MIN   = 16'sh8000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [MG_W-1:0]            mg_t;
  typedef logic [FACTOR_W-1:0]        factor_t;
  typedef logic [GAIN_W-1:0]          gain_t;
  typedef logic signed [TERM_W-1:0]   term_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  typedef struct packed {
    logic [15:0] master;
    logic [63:0] gains;
    logic [63:0] pans;
    logic [3:0]  mute;
    logic [2:0]  solo;
  } cfg_t;

  // Load enables of the five pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

endpackage

// ===== sv/smix_gain.sv =====
// ----------------------------------------------------------------------------
// smix_gain: channel selection and gain computation
// Stage 1 applies mute and solo, clamps the pan and forms master times
// channel gain. Stage 2 scales that by the pan factors and rounds to Q.16.
// ----------------------------------------------------------------------------
module smix_gain #(
  parameter int CHANNELS = 4
) (
  input  logic                clk,
  input  smix_pkg::cfg_t      cfg,
  input  smix_pkg::stage_en_t en,
  input  smix_pkg::sample_t   samples [smix_pkg::MAX_CH],
  output smix_pkg::sample_t   sample_q [CHANNELS],
  output smix_pkg::gain_t     gain_l [CHANNELS],
  output smix_pkg::gain_t     gain_r [CHANNELS]
);
  import smix_pkg::*;

  logic    solo_on;
  sample_t s1_sample [CHANNELS];
  mg_t     s1_mg [CHANNELS];
  factor_t s1_fl [CHANNELS];
  factor_t s1_fr [CHANNELS];

  assign solo_on = int'(cfg.solo) < CHANNELS;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    logic                       live;
    logic signed [FIELD_W-1:0]  pan_raw;
    logic signed [FIELD_W-1:0]  pan_c;
    logic signed [FIELD_W:0]    fl_w;
    logic signed [FIELD_W:0]    fr_w;
    logic [SCALED_W-1:0]        scaled_l;
    logic [SCALED_W-1:0]        scaled_r;

    always_comb begin
      live    = !cfg.mute[c] && (!solo_on || int'(cfg.solo) == c);
      pan_raw = cfg.pans[FIELD_W*c +: FIELD_W];
      if (pan_raw > PAN_UNITY) begin
        pan_c = PAN_UNITY;
      end else if (pan_raw < -PAN_UNITY) begin
        pan_c = -PAN_UNITY;
      end else begin
        pan_c = pan_raw;
      end
      fl_w = (FIELD_W+1)'(PAN_UNITY) - (FIELD_W+1)'(pan_c);
      fr_w = (FIELD_W+1)'(PAN_UNITY) + (FIELD_W+1)'(pan_c);
    end

    // A silenced channel enters with a zero sample, so its terms vanish.
    always_ff @(posedge clk) begin
      if (en.s1) begin
        s1_sample[c] <= live ? samples[c] : '0;
        s1_mg[c]     <= MG_W'(cfg.master) * MG_W'(cfg.gains[FIELD_W*c +: FIELD_W]);
        s1_fl[c]     <= fl_w[FACTOR_W-1:0];
        s1_fr[c]     <= fr_w[FACTOR_W-1:0];
      end
    end

    assign scaled_l = SCALED_W'(s1_mg[c]) * SCALED_W'(s1_fl[c]) + ROUND_Q24;
    assign scaled_r = SCALED_W'(s1_mg[c]) * SCALED_W'(s1_fr[c]) + ROUND_Q24;

    always_ff @(posedge clk) begin
      if (en.s2) begin
        sample_q[c] <= s1_sample[c];
        gain_l[c]   <= scaled_l[SCALED_W-1 -: GAIN_W];
        gain_r[c]   <= scaled_r[SCALED_W-1 -: GAIN_W];
      end
    end
  end

endmodule

// ===== sv/smix_accum.sv =====
// ----------------------------------------------------------------------------
// smix_accum: per-channel products and stereo sums
// Stage 3 multiplies each sample by its left and right gain. Stage 4 adds
// the channel terms into exact Q.31 left and right sums.
// ----------------------------------------------------------------------------
module smix_accum #(
  parameter int CHANNELS = 4
) (
  input  logic                clk,
  input  smix_pkg::stage_en_t en,
  input  smix_pkg::sample_t   sample_q [CHANNELS],
  input  smix_pkg::gain_t     gain_l [CHANNELS],
  input  smix_pkg::gain_t     gain_r [CHANNELS],
  output smix_pkg::sum_t      sum_l,
  output smix_pkg::sum_t      sum_r
);
  import smix_pkg::*;

  term_t term_l [CHANNELS];
  term_t term_r [CHANNELS];
  sum_t  sum_l_next;
  sum_t  sum_r_next;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    always_ff @(posedge clk) begin
      if (en.s3) begin
        term_l[c] <= TERM_W'(sample_q[c]) * TERM_W'($signed({1'b0, gain_l[c]}));
        term_r[c] <= TERM_W'(sample_q[c]) * TERM_W'($signed({1'b0, gain_r[c]}));
      end
    end
  end

  always_comb begin
    sum_l_next = '0;
    sum_r_next = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      sum_l_next = sum_l_next + SUM_W'(term_l[c]);
      sum_r_next = sum_r_next + SUM_W'(term_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      sum_l <= sum_l_next;
      sum_r <= sum_r_next;
    end
  end

endmodule

// ===== sv/smix_round.sv =====
// ----------------------------------------------------------------------------
// smix_round: rounding and saturation
// Rounds the Q.31 sums half up to Q.15, saturates both to 16 bits and
// holds the finished word in the output register.
// ----------------------------------------------------------------------------
module smix_round (
  input  logic                clk,
  input  smix_pkg::stage_en_t en,
  input  smix_pkg::sum_t      sum_l,
  input  smix_pkg::sum_t      sum_r,
  output smix_pkg::sample_t   left_q,
  output smix_pkg::sample_t   right_q,
  output logic                clip_q
);
  import smix_pkg::*;

  localparam int RW = SUM_W - OUT_SHIFT;

  sum_t              biased_l;
  sum_t              biased_r;
  logic signed [RW-1:0] round_l;
  logic signed [RW-1:0] round_r;
  logic              hi_l;
  logic              lo_l;
  logic              hi_r;
  logic              lo_r;
  sample_t           left_next;
  sample_t           right_next;

  always_comb begin
    biased_l = sum_l + ROUND_Q16;
    biased_r = sum_r + ROUND_Q16;
    round_l  = biased_l[SUM_W-1:OUT_SHIFT];
    round_r  = biased_r[SUM_W-1:OUT_SHIFT];
    hi_l     = round_l > RW'(OUT_MAX);
    lo_l     = round_l < RW'(OUT_MIN);
    hi_r     = round_r > RW'(OUT_MAX);
    lo_r     = round_r < RW'(OUT_MIN);
    if (hi_l) begin
      left_next = OUT_MAX;
    end else if (lo_l) begin
      left_next = OUT_MIN;
    end else begin
      left_next = round_l[SAMPLE_W-1:0];
    end
    if (hi_r) begin
      right_next = OUT_MAX;
    end else if (lo_r) begin
      right_next = OUT_MIN;
    end else begin
      right_next = round_r[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      left_q  <= left_next;
      right_q <= right_next;
      clip_q  <= hi_l | lo_l | hi_r | lo_r;
    end
  end

endmodule

// ===== sv/stereo_pan_mixer.sv =====
// ----------------------------------------------------------------------------
// stereo_pan_mixer: stereo mixer with linear pan, mute and solo
//
//   channel | signals                                  | moves
//   --------+------------------------------------------+--------------------
//   input   | in_valid, in_ready, sample_ch0..3        | one frame a word
//   output  | out_valid, out_ready, left_out,          | one stereo word
//           | right_out, clipped                       |
//   config  | cfg_wr_en, cfg_index, cfg_data           | one register write
//
// Five register stages: gain product, pan scaling, sample products, sums,
// rounding with the output register. One word is taken per cycle unless an
// output stall has filled every stage; each word passes the stages in order.
// Reset clears the valid bits and loads the register defaults.
// A stall at the output fills bubbles first, then holds every stage.
// ----------------------------------------------------------------------------
module stereo_pan_mixer #(
  parameter int CHANNELS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  smix_pkg::sample_t                   sample_ch0,
  input  smix_pkg::sample_t                   sample_ch1,
  input  smix_pkg::sample_t                   sample_ch2,
  input  smix_pkg::sample_t                   sample_ch3,
  output logic                                out_valid,
  input  logic                                out_ready,
  output smix_pkg::sample_t                   left_out,
  output smix_pkg::sample_t                   right_out,
  output logic                                clipped,
  input  logic                                cfg_wr_en,
  input  logic [smix_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [smix_pkg::CFG_W-1:0]          cfg_data
);
  import smix_pkg::*;

  cfg_t      cfg;
  stage_en_t en;
  logic [4:0] valid;
  sample_t   samples [MAX_CH];
  sample_t   sample_q [CHANNELS];
  gain_t     gain_l [CHANNELS];
  gain_t     gain_r [CHANNELS];
  sum_t      sum_l;
  sum_t      sum_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.master <= MASTER_RESET;
      cfg.gains  <= GAINS_RESET;
      cfg.pans   <= PANS_RESET;
      cfg.mute   <= MUTE_RESET;
      cfg.solo   <= SOLO_NONE;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MASTER_GAIN:   cfg.master <= cfg_data[15:0];
        REG_CHANNEL_GAINS: cfg.gains  <= cfg_data;
        REG_CHANNEL_PANS:  cfg.pans   <= cfg_data;
        REG_MUTE_MASK:     cfg.mute   <= cfg_data[3:0];
        REG_SOLO_CHANNEL:  cfg.solo   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en.s5 = !valid[4] || out_ready;
    en.s4 = !valid[3] || en.s5;
    en.s3 = !valid[2] || en.s4;
    en.s2 = !valid[1] || en.s3;
    en.s1 = !valid[0] || en.s2;
  end

  assign in_ready  = en.s1;
  assign out_valid = valid[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en.s1) valid[0] <= in_valid;
      if (en.s2) valid[1] <= valid[0];
      if (en.s3) valid[2] <= valid[1];
      if (en.s4) valid[3] <= valid[2];
      if (en.s5) valid[4] <= valid[3];
    end
  end

  assign samples[0] = sample_ch0;
  assign samples[1] = sample_ch1;
  assign samples[2] = sample_ch2;
  assign samples[3] = sample_ch3;

  smix_gain #(
    .CHANNELS(CHANNELS)
  ) u_gain (
    .clk      (clk),
    .cfg      (cfg),
    .en       (en),
    .samples  (samples),
    .sample_q (sample_q),
    .gain_l   (gain_l),
    .gain_r   (gain_r)
  );

  smix_accum #(
    .CHANNELS(CHANNELS)
  ) u_accum (
    .clk      (clk),
    .en       (en),
    .sample_q (sample_q),
    .gain_l   (gain_l),
    .gain_r   (gain_r),
    .sum_l    (sum_l),
    .sum_r    (sum_r)
  );

  smix_round u_round (
    .clk     (clk),
    .en      (en),
    .sum_l   (sum_l),
    .sum_r   (sum_r),
    .left_q  (left_out),
    .right_q (right_out),
    .clip_q  (clipped)
  );

endmodule

// ===== tb/tb_stereo_pan_mixer.sv =====
// ----------------------------------------------------------------------------
// tb_stereo_pan_mixer: self-checking bench for the stereo pan mixer
// Drives frames through the valid/ready input with random gaps, stalls the
// output at random and once for a long stretch, and predicts every stereo
// word from a fixed-point copy of the mix. Configuration is reloaded between
// phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_stereo_pan_mixer;
  import smix_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 120;
  localparam int LONG_HOLD   = 400;

  typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    clip;
  } mix_word_t;

  class mix_scoreboard;
    logic [15:0] master;
    logic [63:0] gains;
    logic [63:0] pans;
    logic [3:0]  mute;
    logic [2:0]  solo;
    mix_word_t   expected_q[$];
    int          errors;

    function new();
      master = 16'd4096;
      gains  = 64'h4000_4000_4000_4000;
      pans   = 64'h0;
      mute   = 4'h0;
      solo   = 3'd4;
      errors = 0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_MASTER_GAIN:   master = data[15:0];
        REG_CHANNEL_GAINS: gains  = data;
        REG_CHANNEL_PANS:  pans   = data;
        REG_MUTE_MASK:     mute   = data[3:0];
        REG_SOLO_CHANNEL:  solo   = data[2:0];
        default: ;
      endcase
    endfunction

    // Rounds a Q.31 sum half up to Q1.15 and saturates it.
    function sample_t round_sat(longint sum, ref logic clip);
      longint r;
      r = (sum + 64'sd32768) >>> 16;
      if (r > 32767) begin
        clip = 1'b1;
        return OUT_MAX;
      end
      if (r < -32768) begin
        clip = 1'b1;
        return OUT_MIN;
      end
      return sample_t'(r);
    endfunction

    function mix_word_t mix_frame(sample_t s0, sample_t s1, sample_t s2, sample_t s3);
      sample_t           smp [4];
      logic signed [15:0] pan_raw;
      longint            sum_l, sum_r, pan, s_val;
      longint unsigned   m_u, g_u, f_l, f_r, g_l, g_r;
      logic              solo_on, clip;
      int                c;
      mix_word_t         w;
      smp[0] = s0;
      smp[1] = s1;
      smp[2] = s2;
      smp[3] = s3;
      sum_l = 0;
      sum_r = 0;
      clip = 1'b0;
      solo_on = (solo < 3'd4);
      m_u = 64'(master);
      for (c = 0; c < 4; c++) begin
        if (mute[c]) continue;
        if (solo_on && solo != c) continue;
        g_u = 64'(gains[16*c +: 16]);
        pan_raw = pans[16*c +: 16];
        pan = longint'(pan_raw);
        if (pan > 16384) pan = 16384;
        if (pan < -16384) pan = -16384;
        f_l = 16384 - pan;
        f_r = 16384 + pan;
        g_l = (m_u * g_u * f_l + 64'd8388608) >> 24;
        g_r = (m_u * g_u * f_r + 64'd8388608) >> 24;
        s_val = longint'(smp[c]);
        sum_l += s_val * longint'(g_l);
        sum_r += s_val * longint'(g_r);
      end
      w.left  = round_sat(sum_l, clip);
      w.right = round_sat(sum_r, clip);
      w.clip  = clip;
      return w;
    endfunction

    function void note_input(sample_t s0, sample_t s1, sample_t s2, sample_t s3);
      expected_q.push_back(mix_frame(s0, s1, s2, s3));
    endfunction

    function void check_result(sample_t left, sample_t right, logic clip);
      mix_word_t w;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word left %0d right %0d clipped %0b",
                 $time, left, right, clip);
        errors++;
        return;
      end
      w = expected_q.pop_front();
      if (left !== w.left) begin
        $display("%0t: left_out expected %0d actual %0d", $time, w.left, left);
        errors++;
      end
      if (right !== w.right) begin
        $display("%0t: right_out expected %0d actual %0d", $time, w.right, right);
        errors++;
      end
      if (clip !== w.clip) begin
        $display("%0t: clipped expected %0b actual %0b", $time, w.clip, clip);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  sample_t              sample_ch0 = '0;
  sample_t              sample_ch1 = '0;
  sample_t              sample_ch2 = '0;
  sample_t              sample_ch3 = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  sample_t              left_out;
  sample_t              right_out;
  logic                 clipped;
  logic                 cfg_wr_en = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  idle_mode_e    idle_mode = IDLE_NONE;
  logic          hold_req = 1'b0;
  logic          hold_seen = 1'b0;
  int            hold_left = 0;
  int            cycle_count = 0;
  mix_scoreboard sb = new();

  stereo_pan_mixer #(.CHANNELS(4)) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_ch0 (sample_ch0),
    .sample_ch1 (sample_ch1),
    .sample_ch2 (sample_ch2),
    .sample_ch3 (sample_ch3),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .left_out   (left_out),
    .right_out  (right_out),
    .clipped    (clipped),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_input(sample_ch0, sample_ch1, sample_ch2, sample_ch3);
      if (out_valid && out_ready)
        sb.check_result(left_out, right_out, clipped);
    end
  end

  // The one long hold-off is counted here so that the sender keeps pushing
  // words into a full pipeline meanwhile.
  always @(posedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_RX:   out_ready <= ($urandom_range(99) >= 80);
        IDLE_BOTH: out_ready <= ($urandom_range(99) >= 34);
        default:   out_ready <= 1'b1;
      endcase
    end
  end

  function automatic logic tx_gap();
    case (idle_mode)
      IDLE_TX:   return ($urandom_range(99) < 80);
      IDLE_BOTH: return ($urandom_range(99) < 34);
      default:   return 1'b0;
    endcase
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(3))
      0:       return sample_t'($urandom_range(2048) - 1024);
      1:       return $urandom_range(1) ? OUT_MAX : OUT_MIN;
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_frame(input sample_t s0, input sample_t s1,
                            input sample_t s2, input sample_t s3);
    while (tx_gap()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    sample_ch0 <= s0;
    sample_ch1 <= s1;
    sample_ch2 <= s2;
    sample_ch3 <= s3;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering words and waits until every expected word is back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Narrow registers get random junk above their width, and one write goes
  // to an index past the register list.
  task automatic load_config(input logic [15:0] m, input logic [63:0] g,
                             input logic [63:0] p, input logic [3:0] mu,
                             input logic [2:0] so);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    put_reg(REG_MASTER_GAIN, {junk[63:16], m});
    put_reg(REG_CHANNEL_GAINS, g);
    put_reg(REG_CHANNEL_PANS, p);
    put_reg(REG_MUTE_MASK, {junk[63:4], mu});
    put_reg(REG_SOLO_CHANNEL, {junk[63:3], so});
    put_reg(REG_IDX_W'(5 + $urandom_range(2)), {$urandom, $urandom});
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_config(input int kind);
    logic [15:0] m;
    logic [63:0] g, p;
    logic [3:0]  mu;
    logic [2:0]  so;
    int          c;
    case (kind)
      0: begin
        m = 16'($urandom_range(40960));
        for (c = 0; c < 4; c++) begin
          g[16*c +: 16] = 16'($urandom_range(32768));
          p[16*c +: 16] = 16'($urandom_range(32768) - 16384);
        end
        mu = $urandom_range(1) ? 4'h0 : 4'($urandom);
        so = 3'($urandom_range(4));
      end
      1: begin
        m  = 16'($urandom);
        g  = {$urandom, $urandom};
        p  = {$urandom, $urandom};
        mu = 4'($urandom);
        so = 3'($urandom);
      end
      default: begin
        m = $urandom_range(1) ? 16'hffff : 16'd40960;
        g = 64'hffff_ffff_ffff_ffff;
        for (c = 0; c < 4; c++) begin
          case ($urandom_range(3))
            0:       p[16*c +: 16] = 16'h8000;
            1:       p[16*c +: 16] = 16'h7fff;
            2:       p[16*c +: 16] = 16'h4000;
            default: p[16*c +: 16] = 16'hc000;
          endcase
        end
        mu = 4'h0;
        so = $urandom_range(1) ? SOLO_NONE : 3'($urandom_range(3));
      end
    endcase
    load_config(m, g, p, mu, so);
  endtask

  initial begin
    int ph, i;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);

    // Default registers: every channel at unity, so full-scale frames clip.
    send_frame(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_frame(OUT_MAX, OUT_MAX, OUT_MAX, OUT_MAX);
    send_frame(OUT_MIN, OUT_MIN, OUT_MIN, OUT_MIN);
    send_frame(16'sh0001, -16'sh0001, OUT_MAX, OUT_MIN);
    send_frame(16'sh0064, 16'sh0000, 16'sh0000, 16'sh0000);
    settle();

    // Largest gains, pans at and beyond both ends, solo value with no channel.
    load_config(16'hffff, 64'hffff_ffff_ffff_ffff, 64'hc000_4000_7fff_8000,
                4'h0, 3'd7);
    send_frame(OUT_MAX, OUT_MAX, OUT_MAX, OUT_MAX);
    send_frame(OUT_MIN, 16'sh0000, 16'sh0000, 16'sh0000);
    send_frame(16'sh0000, 16'sh0001, -16'sh0001, 16'sh0000);
    send_frame(16'sh5555, -16'sh5556, 16'sh2aaa, -16'sh2aab);
    settle();

    // Solo on a muted channel silences everything.
    load_config(16'd4096, 64'h4000_4000_4000_4000, 64'h0, 4'b0101, 3'd2);
    send_frame(OUT_MAX, OUT_MAX, OUT_MAX, OUT_MAX);
    send_frame(OUT_MIN, OUT_MIN, OUT_MIN, OUT_MIN);
    send_frame(16'sh1234, -16'sh4321, 16'sh7000, -16'sh0700);
    settle();

    load_config(16'd40960, 64'h0000_8000_4000_2000, 64'h0000_0000_2000_0000,
                4'b0001, 3'd1);
    send_frame(OUT_MAX, 16'sh0100, OUT_MIN, OUT_MAX);
    send_frame(OUT_MIN, -16'sh0100, OUT_MAX, OUT_MIN);
    send_frame(16'sh0000, 16'sh0ccc, 16'sh0000, 16'sh0000);
    settle();

    load_config(16'h0000, 64'h0, {$urandom, $urandom}, 4'hf, 3'd0);
    send_frame(OUT_MAX, OUT_MIN, OUT_MAX, OUT_MIN);
    send_frame(OUT_MIN, OUT_MAX, OUT_MIN, OUT_MAX);
    settle();

    for (ph = 0; ph < 8; ph++) begin
      idle_mode <= idle_mode_e'(ph % 4);
      random_config(ph % 3);
      if (ph == 4)
        hold_req <= 1'b1;
      for (i = 0; i < PHASE_ITEMS; i++)
        send_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample());
      settle();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
